>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared assertion macros for the lru replacement cache rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> rtl/core/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// types and constants shared by the lru replacement cache modules
// ----------------------------------------------------------------------------
`default_nettype none

package lrc_pkg;

    localparam int WAYS    = 8;
    localparam int SLOT_W  = 3;
    localparam int PAGE_W  = 16;
    localparam int CNT_W   = 32;
    localparam int K_W     = 4;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [PAGE_W-1:0] t_page;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [K_W-1:0]    t_ways;

    // priority chain passed from lower to higher slot cells
    typedef struct packed {
        logic hit_seen;
        logic empty_seen;
    } t_scan;

    // chain passed along the recency cells
    typedef struct packed {
        logic pos_seen;
        logic lru_seen;
    } t_rec_chain;

endpackage

`default_nettype wire

>>> rtl/core/lru_replacement_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_replacement_cache_unit
// fully associative cache tag store with least-recently-used replacement
// ----------------------------------------------------------------------------
// flow: lookup state, then update state, then the registered result strobe;
//   busy covers lookup and update and no request is accepted while busy; the
//   recency stack and slot cells are written in the update cycle
// reset: slots empty, recency stack in slot order, totals zero, ways_in_use 8
// the result is shown for one cycle on o_valid; the receiver cannot stall
`default_nettype none

`include "assert_macros.svh"

module lru_replacement_cache_unit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire lrc_pkg::t_page  i_page,
    input  wire logic            i_cfg_we,
    input  wire lrc_pkg::t_ways  i_cfg_data,
    output logic                 o_valid,
    output logic                 o_hit,
    output lrc_pkg::t_slot       o_slot,
    output logic                 o_evicted_valid,
    output lrc_pkg::t_page       o_evicted_page,
    output lrc_pkg::t_cnt        o_miss_total,
    output lrc_pkg::t_cnt        o_hit_total
);
    import lrc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state, n_state;
    t_ways      r_ways_cfg;
    t_ways      w_ways;
    t_page      r_page;
    logic       r_hit;
    t_slot      r_slot;
    logic       r_ev_valid;
    t_page      r_ev_page;
    t_cnt       r_miss_cnt, n_miss_cnt;
    t_cnt       r_hit_cnt, n_hit_cnt;
    logic       r_strobe;

    t_scan      w_scan  [WAYS+1];
    t_rec_chain w_chain [WAYS+1];
    logic [WAYS-1:0] w_first_hit, w_first_empty, w_valid, w_lru_first, w_wr;
    t_page      w_page  [WAYS];
    t_slot      w_entry [WAYS];
    t_slot      w_next  [WAYS];
    t_slot      w_hit_slot, w_empty_slot, w_lru_slot, w_sel_slot;
    logic       w_touch;

    // size clamp: zero acts as one, above the slot count saturates
    always_comb begin
        if (r_ways_cfg == '0) begin
            w_ways = t_ways'(1);
        end else if (r_ways_cfg > t_ways'(WAYS)) begin
            w_ways = t_ways'(WAYS);
        end else begin
            w_ways = r_ways_cfg;
        end
    end

    assign w_scan[0]  = '0;
    assign w_chain[0] = '0;
    assign w_touch    = (r_state == S_UPD);

    for (genvar g = 0; g < WAYS; g++) begin : g_cells
        assign w_wr[g] = w_touch && !r_hit && (r_slot == t_slot'(g));

        lrc_slot_cell u_slot (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_wr         (w_wr[g]),
            .i_page       (r_page),
            .i_active     ({1'b0, t_slot'(g)} < w_ways),
            .i_scan       (w_scan[g]),
            .o_scan       (w_scan[g+1]),
            .o_first_hit  (w_first_hit[g]),
            .o_first_empty(w_first_empty[g]),
            .o_page       (w_page[g]),
            .o_valid      (w_valid[g])
        );

        if (g == WAYS - 1) begin : g_top
            assign w_next[g] = r_slot;
        end else begin : g_mid
            assign w_next[g] = w_entry[g+1];
        end

        lrc_rec_cell u_rec (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_init     (t_slot'(g)),
            .i_touch    (w_touch),
            .i_slot     (r_slot),
            .i_next     (w_next[g]),
            .i_ways     (w_ways),
            .i_chain    (w_chain[g]),
            .o_chain    (w_chain[g+1]),
            .o_lru_first(w_lru_first[g]),
            .o_entry    (w_entry[g])
        );
    end

    // one-hot selects folded into slot numbers
    always_comb begin
        w_hit_slot   = '0;
        w_empty_slot = '0;
        w_lru_slot   = '0;
        for (int i = 0; i < WAYS; i++) begin
            w_hit_slot   = w_hit_slot   | (w_first_hit[i]   ? t_slot'(i) : '0);
            w_empty_slot = w_empty_slot | (w_first_empty[i] ? t_slot'(i) : '0);
            w_lru_slot   = w_lru_slot   | (w_lru_first[i]   ? w_entry[i] : '0);
        end
    end

    always_comb begin
        if (w_scan[WAYS].hit_seen) begin
            w_sel_slot = w_hit_slot;
        end else if (w_scan[WAYS].empty_seen) begin
            w_sel_slot = w_empty_slot;
        end else begin
            w_sel_slot = w_lru_slot;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_miss_cnt = r_miss_cnt;
        n_hit_cnt  = r_hit_cnt;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_IDLE;
                if (r_hit) begin
                    if (r_hit_cnt != '1) begin
                        n_hit_cnt = r_hit_cnt + t_cnt'(1);
                    end
                end else if (r_miss_cnt != '1) begin
                    n_miss_cnt = r_miss_cnt + t_cnt'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ways_cfg <= t_ways'(WAYS);
            r_miss_cnt <= '0;
            r_hit_cnt  <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_miss_cnt <= n_miss_cnt;
            r_hit_cnt  <= n_hit_cnt;
            r_strobe   <= (r_state == S_UPD);
            if (i_cfg_we) begin
                r_ways_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_page <= i_page;
        end
        if (r_state == S_LOOK) begin
            r_hit      <= w_scan[WAYS].hit_seen;
            r_slot     <= w_sel_slot;
            r_ev_valid <= !w_scan[WAYS].hit_seen && !w_scan[WAYS].empty_seen;
            r_ev_page  <= (!w_scan[WAYS].hit_seen && !w_scan[WAYS].empty_seen)
                          ? w_page[w_lru_slot] : '0;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_strobe;
    assign o_hit           = r_hit;
    assign o_slot          = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_miss_total    = r_miss_cnt;
    assign o_hit_total     = r_hit_cnt;

    `ASSERT_CLK(a_strobe_idle, r_strobe |-> r_state == S_IDLE, "strobe outside idle")
    `ASSERT_CLK(a_look_upd, r_state == S_LOOK |=> r_state == S_UPD, "lookup not followed by update")
    `ASSERT_CLK(a_hit_onehot, $onehot0(w_first_hit) && $onehot0(w_lru_first), "select not one-hot")
    `ASSERT_CLK(a_slot_filled, r_strobe |-> w_valid[r_slot], "result slot not valid")

endmodule

`default_nettype wire

>>> rtl/core/lrc_slot_cell.sv
// ----------------------------------------------------------------------------
// lrc_slot_cell
// one cache slot: page tag, valid bit, tag compare and priority chain stage
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_slot_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire lrc_pkg::t_page  i_page,
    input  wire logic            i_active,
    input  wire lrc_pkg::t_scan  i_scan,
    output lrc_pkg::t_scan       o_scan,
    output logic                 o_first_hit,
    output logic                 o_first_empty,
    output lrc_pkg::t_page       o_page,
    output logic                 o_valid
);
    import lrc_pkg::*;

    t_page r_page;
    logic  r_valid;
    logic  w_match;
    logic  w_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_page <= i_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr) begin
            r_valid <= 1'b1;
        end
    end

    assign w_match = i_active && r_valid && (r_page == i_page);
    assign w_empty = i_active && !r_valid;

    assign o_first_hit       = w_match && !i_scan.hit_seen;
    assign o_first_empty     = w_empty && !i_scan.empty_seen;
    assign o_scan.hit_seen   = i_scan.hit_seen | w_match;
    assign o_scan.empty_seen = i_scan.empty_seen | w_empty;
    assign o_page            = r_page;
    assign o_valid           = r_valid;

endmodule

`default_nettype wire

>>> rtl/core/lrc_rec_cell.sv
// ----------------------------------------------------------------------------
// lrc_rec_cell
// one entry of the recency stack; shifts down from its neighbor on a touch
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_rec_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lrc_pkg::t_slot      i_init,
    input  wire logic                i_touch,
    input  wire lrc_pkg::t_slot      i_slot,
    input  wire lrc_pkg::t_slot      i_next,
    input  wire lrc_pkg::t_ways      i_ways,
    input  wire lrc_pkg::t_rec_chain i_chain,
    output lrc_pkg::t_rec_chain      o_chain,
    output logic                     o_lru_first,
    output lrc_pkg::t_slot           o_entry
);
    import lrc_pkg::*;

    t_slot r_entry;
    logic  w_in_use;

    // entries at and above the touched slot's position take the neighbor's value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= i_init;
        end else if (i_touch && o_chain.pos_seen) begin
            r_entry <= i_next;
        end
    end

    assign w_in_use         = {1'b0, r_entry} < i_ways;
    assign o_chain.pos_seen = i_chain.pos_seen | (r_entry == i_slot);
    assign o_chain.lru_seen = i_chain.lru_seen | w_in_use;
    assign o_lru_first      = w_in_use && !i_chain.lru_seen;
    assign o_entry          = r_entry;

endmodule

`default_nettype wire

>>> sim/lru_replacement_cache_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_replacement_cache_checker
// watches the request, config and result ports of the lru cache, keeps its
// own copy of the tag store and recency order, predicts every result and
// compares it field by field with what the block returns
// ----------------------------------------------------------------------------

module lru_replacement_cache_checker (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire logic            busy,
    input  wire lrc_pkg::t_page  i_page,
    input  wire logic            i_cfg_we,
    input  wire lrc_pkg::t_ways  i_cfg_data,
    input  wire logic            o_valid,
    input  wire logic            o_hit,
    input  wire lrc_pkg::t_slot  o_slot,
    input  wire logic            o_evicted_valid,
    input  wire lrc_pkg::t_page  o_evicted_page,
    input  wire lrc_pkg::t_cnt   o_miss_total,
    input  wire lrc_pkg::t_cnt   o_hit_total,
    output int                   fail_count,
    output int                   pending
);
    import lrc_pkg::*;

    typedef struct packed {
        logic  hit;
        t_slot slot;
        logic  ev_valid;
        t_page ev_page;
        t_cnt  miss_total;
        t_cnt  hit_total;
    } t_lookup;

    // shadow of the cache state
    t_page   tag_page [WAYS];
    logic    tag_valid [WAYS];
    t_slot   lru_order [WAYS];   // index 0 is least recently used
    t_cnt    misses;
    t_cnt    hits;
    t_ways   ways_cfg;

    t_lookup lookups_due [$];
    t_lookup got;
    t_lookup due;

    initial fail_count = 0;
    initial pending = 0;

    function automatic void reset_shadow();
        for (int i = 0; i < WAYS; i++) begin
            tag_page[i]  = '0;
            tag_valid[i] = 1'b0;
            lru_order[i] = t_slot'(i);
        end
        misses   = '0;
        hits     = '0;
        ways_cfg = t_ways'(WAYS);
    endfunction

    function automatic void promote(t_slot s);
        int pos;
        pos = 0;
        for (int i = 0; i < WAYS; i++)
            if (lru_order[i] == s) pos = i;
        for (int i = pos; i + 1 < WAYS; i++)
            lru_order[i] = lru_order[i + 1];
        lru_order[WAYS-1] = s;
    endfunction

    function automatic t_lookup lookup_page(t_page page);
        t_lookup r;
        int      k;
        logic    found;
        r     = '0;
        found = 1'b0;
        k     = int'(ways_cfg);
        if (k < 1) k = 1;
        if (k > WAYS) k = WAYS;
        for (int i = 0; i < k && !found; i++)
            if (tag_valid[i] && tag_page[i] == page) begin
                r.slot = t_slot'(i);
                r.hit  = 1'b1;
                found  = 1'b1;
            end
        // first empty slot in use
        for (int i = 0; i < k && !found; i++)
            if (!tag_valid[i]) begin
                r.slot = t_slot'(i);
                found  = 1'b1;
            end
        // oldest slot that is still in use
        for (int i = 0; i < WAYS && !found; i++)
            if (int'(lru_order[i]) < k) begin
                r.slot     = lru_order[i];
                r.ev_valid = 1'b1;
                r.ev_page  = tag_page[lru_order[i]];
                found      = 1'b1;
            end
        if (r.hit) begin
            if (hits != '1) hits = hits + 1'b1;
        end else begin
            if (misses != '1) misses = misses + 1'b1;
            tag_page[r.slot]  = page;
            tag_valid[r.slot] = 1'b1;
        end
        promote(r.slot);
        r.miss_total = misses;
        r.hit_total  = hits;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_shadow();
            lookups_due.delete();
        end else begin
            if (o_valid) begin
                got = '{o_hit, o_slot, o_evicted_valid, o_evicted_page,
                        o_miss_total, o_hit_total};
                if (lookups_due.size() == 0) begin
                    $error("result beat with no request outstanding");
                    fail_count++;
                end else begin
                    due = lookups_due.pop_front();
                    check_field("hit", 32'(due.hit), 32'(got.hit));
                    check_field("slot", 32'(due.slot), 32'(got.slot));
                    check_field("evicted_valid", 32'(due.ev_valid), 32'(got.ev_valid));
                    check_field("evicted_page", 32'(due.ev_page), 32'(got.ev_page));
                    check_field("miss_total", due.miss_total, got.miss_total);
                    check_field("hit_total", due.hit_total, got.hit_total);
                end
            end
            if (start && !busy)
                lookups_due = {lookups_due, lookup_page(i_page)};
            if (i_cfg_we)
                ways_cfg = i_cfg_data;
        end
        pending <= lookups_due.size();
    end

endmodule

>>> sim/lru_replacement_cache_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_replacement_cache_unit_tb
// drives page requests and cache size changes into the lru cache unit: a
// directed part for fill, hit, eviction, page zero and odd sizes, then
// phases of random requests drawn mostly from small page pools
// ----------------------------------------------------------------------------

module lru_replacement_cache_unit_tb;
    import lrc_pkg::*;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_page i_page = '0;
    logic  i_cfg_we = 1'b0;
    t_ways i_cfg_data = '0;
    logic  o_valid;
    logic  o_hit;
    t_slot o_slot;
    logic  o_evicted_valid;
    t_page o_evicted_page;
    t_cnt  o_miss_total;
    t_cnt  o_hit_total;
    int    fail_count;
    int    pending;

    int    gap_mode;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    lru_replacement_cache_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page          (i_page),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_miss_total    (o_miss_total),
        .o_hit_total     (o_hit_total)
    );

    lru_replacement_cache_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page          (i_page),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_miss_total    (o_miss_total),
        .o_hit_total     (o_hit_total),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    function automatic int draw_gap();
        case (gap_mode)
            0: return 0;
            1: return $urandom_range(0, 19);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
        endcase
    endfunction

    // one request beat; start stays high when the next gap is zero
    task automatic send_page(input t_page page);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_page <= page;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic set_ways(input t_ways value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        t_ways ways_plan [5];
        t_ways w;
        int    k;
        int    pool;
        t_page base;
        ways_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill from reset size, page zero and all-ones, then an eviction
        gap_mode = 1;
        send_page(16'h0000);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0001);
        send_page(16'h0002);
        send_page(16'h8000);
        send_page(16'h7FFF);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'hFFFF);
        send_page(16'h1234);

        // size zero acts as one slot, upper slots keep their pages
        set_ways(4'd0);
        send_page(16'h0F0F);
        send_page(16'h0F0F);
        send_page(16'hFFFF);

        // oversize saturates, the hidden slots come back
        set_ways(4'd15);
        send_page(16'hAAAA);
        send_page(16'h0001);
        send_page(16'hFFFF);
        send_page(16'hBEEF);

        gap_mode = 0;
        set_ways(4'd1);
        send_page(16'h0000);
        send_page(16'h0000);

        for (int ph = 0; ph < 12; ph++) begin
            w = (ph < 5) ? ways_plan[ph] : t_ways'($urandom_range(0, 15));
            set_ways(w);
            k = (w == 0) ? 1 : ((w > WAYS) ? WAYS : int'(w));
            gap_mode = $urandom_range(0, 2);
            pool = $urandom_range(1, 2 * k + 2);
            base = t_page'($urandom);
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 49) == 0)
                    wait_idle();
                if ($urandom_range(0, 99) < 85)
                    send_page(base + t_page'($urandom_range(0, pool - 1)));
                else
                    send_page(t_page'($urandom));
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lrc_pkg.sv
rtl/core/lrc_slot_cell.sv
rtl/core/lrc_rec_cell.sv
rtl/core/lru_replacement_cache_unit.sv
sim/lru_replacement_cache_checker.sv
sim/lru_replacement_cache_unit_tb.sv
